@@ src/rvx_pkg.sv @@
// Shared types, constants and instruction codes of the RV32IM execute step.
package rvx_pkg;

    localparam int XLEN           = 32;
    localparam int REG_IDX_W      = 5;
    localparam int REGISTER_COUNT_DEFAULT = 32;

    // Digit-serial ALU geometry.
    localparam int ALU_DIGIT      = 4;
    localparam int ALU_STEPS      = XLEN / ALU_DIGIT;
    localparam int ALU_CNT_W      = $clog2(ALU_STEPS);

    localparam logic [XLEN-1:0] POISON_WORD = 32'hdeadbeef;

    // Configuration register indexes.
    localparam logic CFG_START_ADDRESS = 1'b0;
    localparam logic CFG_START_SP      = 1'b1;

    // Opcodes.
    localparam logic [6:0] OP_LUI     = 7'h37;
    localparam logic [6:0] OP_AUIPC   = 7'h17;
    localparam logic [6:0] OP_JAL     = 7'h6f;
    localparam logic [6:0] OP_JALR    = 7'h67;
    localparam logic [6:0] OP_BRANCH  = 7'h63;
    localparam logic [6:0] OP_LOAD    = 7'h03;
    localparam logic [6:0] OP_STORE   = 7'h23;
    localparam logic [6:0] OP_IMM     = 7'h13;
    localparam logic [6:0] OP_REG     = 7'h33;
    localparam logic [6:0] OP_FENCE   = 7'h0f;
    localparam logic [6:0] OP_CUSTOM0 = 7'h0b;
    localparam logic [6:0] OP_SYSTEM  = 7'h73;

    localparam logic [XLEN-1:0] INSN_ECALL  = 32'h00000073;
    localparam logic [XLEN-1:0] INSN_EBREAK = 32'h00100073;

    localparam logic [11:0] CSR_CYCLE    = 12'hc00;
    localparam logic [11:0] CSR_INSTRET  = 12'hc02;
    localparam logic [11:0] CSR_CYCLEH   = 12'hc80;
    localparam logic [11:0] CSR_INSTRETH = 12'hc82;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MASKIRQ = 7'h03;
    localparam logic [2:0] F3_MASKIRQ = 3'd6;

    // Result codes.
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_STORE = 2'd2;

    localparam logic [1:0] TRAP_NONE    = 2'd0;
    localparam logic [1:0] TRAP_ILLEGAL = 2'd1;
    localparam logic [1:0] TRAP_HALT    = 2'd2;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_XOR,
        ALU_OR,
        ALU_AND
    } alu_op_t;

    typedef struct packed {
        logic eq;
        logic lt_s;
        logic lt_u;
    } alu_flags_t;

endpackage

@@ src/rvx_regs.sv @@
// Register file: one write port, two registered read ports, reset-value tracking.
module rvx_regs import rvx_pkg::*; #(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [REG_IDX_W-1:0] rd_addr_a,
    input  logic [REG_IDX_W-1:0] rd_addr_b,
    output logic [XLEN-1:0]      rd_data_a,
    output logic [XLEN-1:0]      rd_data_b,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_addr,
    input  logic [XLEN-1:0]      wr_data,
    input  logic [XLEN-1:0]      sp_value,
    input  logic                 sp_load
);

    localparam int IDX_W = $clog2(REGISTER_COUNT);
    localparam logic [REG_IDX_W:0] COUNT_LIMIT = (REG_IDX_W+1)'(REGISTER_COUNT);
    localparam logic [REG_IDX_W-1:0] SP_IDX = REG_IDX_W'(2);

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_POISON,
        SRC_SP,
        SRC_MEM
    } src_t;

    logic [XLEN-1:0]           mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] valid_reg;
    logic [XLEN-1:0]           mem_a_reg;
    logic [XLEN-1:0]           mem_b_reg;
    src_t                      src_a_reg;
    src_t                      src_b_reg;
    src_t                      src_a_next;
    src_t                      src_b_next;
    logic                      wr_ok;

    function automatic src_t classify(input logic [REG_IDX_W-1:0] idx,
                                      input logic [REGISTER_COUNT-1:0] vld);
        src_t s;
        if (idx == '0 || {1'b0, idx} >= COUNT_LIMIT) begin
            s = SRC_ZERO;
        end else if (vld[idx[IDX_W-1:0]]) begin
            s = SRC_MEM;
        end else if (idx == SP_IDX) begin
            s = SRC_SP;
        end else begin
            s = SRC_POISON;
        end
        return s;
    endfunction

    assign src_a_next = classify(rd_addr_a, valid_reg);
    assign src_b_next = classify(rd_addr_b, valid_reg);
    assign wr_ok = wr_en && wr_addr != '0 && {1'b0, wr_addr} < COUNT_LIMIT;

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            mem_a_reg <= mem[rd_addr_a[IDX_W-1:0]];
            mem_b_reg <= mem[rd_addr_b[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            src_a_reg <= SRC_ZERO;
            src_b_reg <= SRC_ZERO;
        end else begin
            if (rd_en) begin
                src_a_reg <= src_a_next;
                src_b_reg <= src_b_next;
            end
            if (sp_load) begin
                valid_reg[SP_IDX[IDX_W-1:0]] <= 1'b0;
            end
            if (wr_ok) begin
                valid_reg[wr_addr[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_comb begin
        case (src_a_reg)
            SRC_ZERO:   rd_data_a = '0;
            SRC_POISON: rd_data_a = POISON_WORD;
            SRC_SP:     rd_data_a = sp_value;
            default:    rd_data_a = mem_a_reg;
        endcase
        case (src_b_reg)
            SRC_ZERO:   rd_data_b = '0;
            SRC_POISON: rd_data_b = POISON_WORD;
            SRC_SP:     rd_data_b = sp_value;
            default:    rd_data_b = mem_b_reg;
        endcase
    end

endmodule

@@ src/rvx_alu.sv @@
// Digit-serial adder, logic unit and comparator, least significant digit first.
module rvx_alu import rvx_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  alu_op_t         op,
    input  logic [XLEN-1:0] x,
    input  logic [XLEN-1:0] y,
    output logic            done,
    output logic [XLEN-1:0] result,
    output alu_flags_t      flags
);

    localparam logic [ALU_CNT_W-1:0] LAST_STEP = ALU_CNT_W'(ALU_STEPS - 1);

    logic [XLEN-1:0]      x_sh_reg;
    logic [XLEN-1:0]      y_sh_reg;
    logic [XLEN-1:0]      res_reg;
    logic                 carry_reg;
    logic                 eq_reg;
    logic                 sx_reg;
    logic                 sy_reg;
    alu_op_t              op_reg;
    logic [ALU_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [ALU_DIGIT-1:0] dx;
    logic [ALU_DIGIT-1:0] dy_raw;
    logic [ALU_DIGIT-1:0] dy;
    logic [ALU_DIGIT:0]   sum;
    logic [ALU_DIGIT-1:0] digit;

    assign dx     = x_sh_reg[ALU_DIGIT-1:0];
    assign dy_raw = y_sh_reg[ALU_DIGIT-1:0];
    assign dy     = (op_reg == ALU_SUB) ? ~dy_raw : dy_raw;
    assign sum    = {1'b0, dx} + {1'b0, dy} + {{ALU_DIGIT{1'b0}}, carry_reg};

    always_comb begin
        case (op_reg)
            ALU_XOR: digit = dx ^ dy_raw;
            ALU_OR:  digit = dx | dy_raw;
            ALU_AND: digit = dx & dy_raw;
            default: digit = sum[ALU_DIGIT-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_sh_reg  <= x;
                y_sh_reg  <= y;
                sx_reg    <= x[XLEN-1];
                sy_reg    <= y[XLEN-1];
                op_reg    <= op;
                carry_reg <= (op == ALU_SUB);
                eq_reg    <= 1'b1;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                x_sh_reg  <= x_sh_reg >> ALU_DIGIT;
                y_sh_reg  <= y_sh_reg >> ALU_DIGIT;
                res_reg   <= {digit, res_reg[XLEN-1:ALU_DIGIT]};
                carry_reg <= sum[ALU_DIGIT];
                eq_reg    <= eq_reg && (dx == dy_raw);
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done       = done_reg;
    assign result     = res_reg;
    assign flags.eq   = eq_reg;
    assign flags.lt_u = ~carry_reg;
    assign flags.lt_s = (sx_reg != sy_reg) ? sx_reg : ~carry_reg;

endmodule

@@ src/rvx_muldiv.sv @@
// Bit-serial multiplier and restoring divider, one bit per cycle.
module rvx_muldiv import rvx_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [2:0]      func,
    input  logic [XLEN-1:0] a,
    input  logic [XLEN-1:0] b,
    output logic            done,
    output logic [XLEN-1:0] result
);

    localparam logic [2:0] F_MUL    = 3'd0;
    localparam logic [2:0] F_MULH   = 3'd1;
    localparam logic [2:0] F_MULHSU = 3'd2;
    localparam logic [2:0] F_MULHU  = 3'd3;
    localparam logic [2:0] F_DIV    = 3'd4;
    localparam logic [2:0] F_DIVU   = 3'd5;
    localparam logic [2:0] F_REM    = 3'd6;
    localparam int CNT_W = $clog2(XLEN);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(XLEN - 1);

    typedef enum logic [1:0] {
        M_IDLE,
        M_LOOP,
        M_FIX1,
        M_FIX2
    } md_state_t;

    md_state_t        state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [2:0]       func_reg;
    logic [XLEN-1:0]  a_reg;
    logic [XLEN-1:0]  b_reg;
    logic             b_neg_reg;
    logic [XLEN-1:0]  hi_reg;
    logic [XLEN-1:0]  lo_reg;
    logic [XLEN-1:0]  res_reg;
    logic             done_reg;

    logic             is_div;
    logic             div_signed;
    logic [XLEN-1:0]  ma;
    logic [XLEN-1:0]  mb;
    logic [XLEN:0]    mul_sum;
    logic [XLEN:0]    div_shift;
    logic [XLEN:0]    div_diff;
    logic [XLEN-1:0]  na_term;
    logic [XLEN-1:0]  nb_term;
    logic [XLEN-1:0]  quo_fix;
    logic [XLEN-1:0]  rem_fix;

    // lo holds the multiplier / quotient, hi the partial product / remainder.
    assign is_div     = func_reg[2];
    assign div_signed = (func == F_DIV) || (func == F_REM);
    assign ma = (div_signed && a[XLEN-1]) ? (~a + 1'b1) : a;
    assign mb = (div_signed && b[XLEN-1]) ? (~b + 1'b1) : b;

    assign mul_sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
    assign div_shift = {hi_reg, lo_reg[XLEN-1]};
    assign div_diff  = div_shift - {1'b0, b_reg};

    assign na_term = (a_reg[XLEN-1] && (func_reg == F_MULH || func_reg == F_MULHSU))
                     ? b_reg : '0;
    assign nb_term = (b_reg[XLEN-1] && func_reg == F_MULH) ? a_reg : '0;

    assign quo_fix = (a_reg[XLEN-1] != b_neg_reg) ? (~lo_reg + 1'b1) : lo_reg;
    assign rem_fix = a_reg[XLEN-1] ? (~hi_reg + 1'b1) : hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        func_reg  <= func;
                        hi_reg    <= '0;
                        cnt_reg   <= '0;
                        b_neg_reg <= b[XLEN-1];
                        if (func[2]) begin
                            a_reg <= a;
                            b_reg <= mb;
                            lo_reg <= ma;
                        end else begin
                            a_reg <= a;
                            b_reg <= b;
                            lo_reg <= b;
                        end
                        state_reg <= M_LOOP;
                    end
                end
                M_LOOP: begin
                    if (is_div) begin
                        if (!div_diff[XLEN]) begin
                            hi_reg <= div_diff[XLEN-1:0];
                            lo_reg <= {lo_reg[XLEN-2:0], 1'b1};
                        end else begin
                            hi_reg <= div_shift[XLEN-1:0];
                            lo_reg <= {lo_reg[XLEN-2:0], 1'b0};
                        end
                    end else begin
                        hi_reg <= mul_sum[XLEN:1];
                        lo_reg <= {mul_sum[0], lo_reg[XLEN-1:1]};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP) begin
                        state_reg <= M_FIX1;
                    end
                end
                M_FIX1: begin
                    if (is_div) begin
                        // b_reg holds the divisor magnitude; b_neg_reg keeps its sign.
                        case (func_reg)
                            F_DIV:   res_reg <= (b_reg == '0) ? '1 : quo_fix;
                            F_DIVU:  res_reg <= lo_reg;
                            F_REM:   res_reg <= rem_fix;
                            default: res_reg <= hi_reg;
                        endcase
                    end else begin
                        hi_reg <= hi_reg - na_term;
                    end
                    state_reg <= M_FIX2;
                end
                M_FIX2: begin
                    if (!is_div) begin
                        res_reg <= (func_reg == F_MUL) ? lo_reg :
                                   (func_reg == F_MULHU) ? hi_reg : (hi_reg - nb_term);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ src/rv32im_execute_step_top.sv @@
// Top level of the RV32IM execute step: decode, sequencing and architectural state.
//
// The block executes one RV32IM instruction word, or applies one load return,
// per input item and delivers exactly one result item for each. An item is
// taken in the idle cycle, the register file is read on that edge, the next
// cycle decodes and launches a unit, and a final cycle commits state and loads
// the output register. Direct operations (LUI, FENCE, counter read, maskirq,
// traps, load returns) go from decode straight to commit. Add, subtract,
// logic, compares, AUIPC, jumps and memory address generation pass once
// through the 4-bit digit-serial ALU; a taken branch runs a second pass for
// its target. Shifts move one bit per cycle until the shift amount is spent.
// Multiply, divide and remainder go through the bit-serial unit.
// A result waits in the output register while the next item is already
// accepted; only the commit cycle holds for a free output slot. Register
// reads of entries never written return 0xdeadbeef (entry two returns the
// configured stack pointer); index zero and indexes at or above the register
// count read zero and ignore writes. Configuration writes are taken at any
// time and are meant for idle periods.
module rv32im_execute_step_top import rvx_pkg::*; #(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic            cfg_index,
    input  logic [XLEN-1:0] cfg_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_operation,
    input  logic [XLEN-1:0] s_instruction_word,
    input  logic [XLEN-1:0] s_load_value,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [XLEN-1:0] m_fetch_address,
    output logic [1:0]      m_memory_request,
    output logic [1:0]      m_access_size,
    output logic [XLEN-1:0] m_access_address,
    output logic [XLEN-1:0] m_store_value,
    output logic [1:0]      m_trap_status,
    output logic [XLEN-1:0] m_trap_address
);

    localparam logic [2:0] LD_B  = 3'd0;
    localparam logic [2:0] LD_H  = 3'd1;
    localparam logic [2:0] LD_BU = 3'd4;
    localparam logic [2:0] LD_HU = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ALU,
        S_SHIFT,
        S_MD,
        S_WB
    } state_t;

    typedef enum logic [3:0] {
        K_ILLEGAL,
        K_HALT,
        K_ALU,
        K_SLT,
        K_SHIFT,
        K_MD,
        K_BRANCH,
        K_JAL,
        K_JALR,
        K_LOAD,
        K_STORE,
        K_DIRECT,
        K_MASKIRQ,
        K_NONE
    } kind_t;

    // Control and item registers.
    state_t          state_reg;
    logic            pass2_reg;
    logic            op_reg;
    logic [XLEN-1:0] insn_reg;
    logic [XLEN-1:0] lval_reg;

    // Serial shifter.
    logic [XLEN-1:0]      sh_data_reg;
    logic [REG_IDX_W-1:0] sh_cnt_reg;
    logic                 sh_left_reg;
    logic                 sh_arith_reg;

    // Staged commit.
    logic                 wb_en_reg;
    logic [REG_IDX_W-1:0] wb_idx_reg;
    logic [XLEN-1:0]      wb_val_reg;
    logic [XLEN-1:0]      next_pc_reg;
    logic                 retire_reg;
    logic [1:0]           trap_new_reg;
    logic [1:0]           req_reg;
    logic [1:0]           size_reg;
    logic [XLEN-1:0]      addr_reg;
    logic [XLEN-1:0]      sdata_reg;
    logic                 mask_wr_reg;
    logic                 load_issue_reg;
    logic                 load_clear_reg;

    // Architectural state.
    logic [XLEN-1:0]      pc_reg;
    logic [2*XLEN-1:0]    retired_reg;
    logic [XLEN-1:0]      mask_reg;
    logic [1:0]           trap_kind_reg;
    logic [XLEN-1:0]      trap_loc_reg;
    logic                 ld_pend_reg;
    logic [REG_IDX_W-1:0] ld_dest_reg;
    logic [2:0]           ld_kind_reg;
    logic [XLEN-1:0]      sp_reg;

    // Output register.
    logic            m_valid_reg;
    logic [XLEN-1:0] m_fetch_reg;
    logic [1:0]      m_req_reg;
    logic [1:0]      m_size_reg;
    logic [XLEN-1:0] m_addr_reg;
    logic [XLEN-1:0] m_sdata_reg;
    logic [1:0]      m_trap_reg;
    logic [XLEN-1:0] m_trap_addr_reg;

    // Decode.
    logic [6:0]           opcode;
    logic [REG_IDX_W-1:0] rd;
    logic [2:0]           f3;
    logic [6:0]           f7;
    logic [11:0]          csr;
    logic [XLEN-1:0]      imm_i;
    logic [XLEN-1:0]      imm_s;
    logic [XLEN-1:0]      imm_b;
    logic [XLEN-1:0]      imm_u;
    logic [XLEN-1:0]      imm_j;
    kind_t                dec_kind;
    alu_op_t              dec_op;
    logic [XLEN-1:0]      dec_x;
    logic [XLEN-1:0]      dec_y;
    logic                 dec_slt_signed;
    logic                 dec_shift_left;
    logic                 dec_shift_arith;
    logic [REG_IDX_W-1:0] dec_shamt;
    logic [XLEN-1:0]      dec_val;
    logic [XLEN-1:0]      csr_val;

    logic [XLEN-1:0]      rf_a;
    logic [XLEN-1:0]      rf_b;
    logic                 rf_wr_en;
    logic                 accept;
    logic                 slot_free;
    logic                 commit;
    logic [XLEN-1:0]      pc_plus4;
    logic [XLEN-1:0]      ld_ext;
    logic                 take;
    logic [XLEN-1:0]      store_masked;

    logic                 alu_start;
    alu_op_t              alu_op;
    logic [XLEN-1:0]      alu_x;
    logic [XLEN-1:0]      alu_y;
    logic                 alu_done;
    logic [XLEN-1:0]      alu_result;
    alu_flags_t           alu_flags;

    logic                 md_start;
    logic                 md_done;
    logic [XLEN-1:0]      md_result;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign commit    = (state_reg == S_WB) && slot_free;
    assign rf_wr_en  = commit && wb_en_reg;
    assign pc_plus4  = pc_reg + XLEN'(4);

    assign opcode = insn_reg[6:0];
    assign rd     = insn_reg[11:7];
    assign f3     = insn_reg[14:12];
    assign f7     = insn_reg[31:25];
    assign csr    = insn_reg[31:20];
    assign imm_i  = {{20{insn_reg[31]}}, insn_reg[31:20]};
    assign imm_s  = {{20{insn_reg[31]}}, insn_reg[31:25], insn_reg[11:7]};
    assign imm_b  = {{19{insn_reg[31]}}, insn_reg[31], insn_reg[7], insn_reg[30:25],
                     insn_reg[11:8], 1'b0};
    assign imm_u  = {insn_reg[31:12], 12'b0};
    assign imm_j  = {{11{insn_reg[31]}}, insn_reg[31], insn_reg[19:12], insn_reg[20],
                     insn_reg[30:21], 1'b0};

    // Counter reads see the count before their own instruction.
    always_comb begin
        if (csr == CSR_CYCLE || csr == CSR_INSTRET) begin
            csr_val = retired_reg[XLEN-1:0];
        end else if (csr == CSR_CYCLEH || csr == CSR_INSTRETH) begin
            csr_val = retired_reg[2*XLEN-1:XLEN];
        end else begin
            csr_val = '0;
        end
    end

    always_comb begin
        dec_kind        = K_ILLEGAL;
        dec_op          = ALU_ADD;
        dec_x           = rf_a;
        dec_y           = rf_b;
        dec_slt_signed  = 1'b0;
        dec_shift_left  = 1'b0;
        dec_shift_arith = 1'b0;
        dec_shamt       = insn_reg[24:20];
        dec_val         = '0;
        case (opcode)
            OP_LUI: begin
                dec_kind = K_DIRECT;
                dec_val  = imm_u;
            end
            OP_AUIPC: begin
                dec_kind = K_ALU;
                dec_x    = pc_reg;
                dec_y    = imm_u;
            end
            OP_JAL: begin
                dec_kind = K_JAL;
                dec_x    = pc_reg;
                dec_y    = imm_j;
            end
            OP_JALR: begin
                if (f3 == 3'd0) begin
                    dec_kind = K_JALR;
                    dec_y    = imm_i;
                end
            end
            OP_BRANCH: begin
                if (f3 != 3'd2 && f3 != 3'd3) begin
                    dec_kind = K_BRANCH;
                    dec_op   = ALU_SUB;
                end
            end
            OP_LOAD: begin
                if (f3 != 3'd3 && f3 <= 3'd5) begin
                    dec_kind = K_LOAD;
                    dec_y    = imm_i;
                end
            end
            OP_STORE: begin
                if (f3 <= 3'd2) begin
                    dec_kind = K_STORE;
                    dec_y    = imm_s;
                end
            end
            OP_IMM: begin
                dec_y = imm_i;
                case (f3)
                    3'd0: dec_kind = K_ALU;
                    3'd2: begin
                        dec_kind       = K_SLT;
                        dec_op         = ALU_SUB;
                        dec_slt_signed = 1'b1;
                    end
                    3'd3: begin
                        dec_kind = K_SLT;
                        dec_op   = ALU_SUB;
                    end
                    3'd4: begin
                        dec_kind = K_ALU;
                        dec_op   = ALU_XOR;
                    end
                    3'd6: begin
                        dec_kind = K_ALU;
                        dec_op   = ALU_OR;
                    end
                    3'd7: begin
                        dec_kind = K_ALU;
                        dec_op   = ALU_AND;
                    end
                    3'd1: begin
                        if (f7 == F7_BASE) begin
                            dec_kind       = K_SHIFT;
                            dec_shift_left = 1'b1;
                        end
                    end
                    default: begin
                        if (f7 == F7_ALT) begin
                            dec_kind        = K_SHIFT;
                            dec_shift_arith = 1'b1;
                        end else if (f7 == F7_BASE) begin
                            dec_kind = K_SHIFT;
                        end
                    end
                endcase
            end
            OP_REG: begin
                dec_shamt = rf_b[REG_IDX_W-1:0];
                if (f7 == F7_MULDIV) begin
                    dec_kind = K_MD;
                end else if (f7 == F7_ALT) begin
                    if (f3 == 3'd0) begin
                        dec_kind = K_ALU;
                        dec_op   = ALU_SUB;
                    end else if (f3 == 3'd5) begin
                        dec_kind        = K_SHIFT;
                        dec_shift_arith = 1'b1;
                    end
                end else if (f7 == F7_BASE) begin
                    case (f3)
                        3'd0: dec_kind = K_ALU;
                        3'd1: begin
                            dec_kind       = K_SHIFT;
                            dec_shift_left = 1'b1;
                        end
                        3'd2: begin
                            dec_kind       = K_SLT;
                            dec_op         = ALU_SUB;
                            dec_slt_signed = 1'b1;
                        end
                        3'd3: begin
                            dec_kind = K_SLT;
                            dec_op   = ALU_SUB;
                        end
                        3'd4: begin
                            dec_kind = K_ALU;
                            dec_op   = ALU_XOR;
                        end
                        3'd5: dec_kind = K_SHIFT;
                        3'd6: begin
                            dec_kind = K_ALU;
                            dec_op   = ALU_OR;
                        end
                        default: begin
                            dec_kind = K_ALU;
                            dec_op   = ALU_AND;
                        end
                    endcase
                end
            end
            OP_FENCE: dec_kind = K_NONE;
            OP_CUSTOM0: begin
                if (f3 == F3_MASKIRQ && f7 == F7_MASKIRQ) begin
                    dec_kind = K_MASKIRQ;
                    dec_val  = mask_reg;
                end
            end
            OP_SYSTEM: begin
                if (insn_reg == INSN_ECALL || insn_reg == INSN_EBREAK) begin
                    dec_kind = K_HALT;
                end else begin
                    dec_kind = K_DIRECT;
                    dec_val  = csr_val;
                end
            end
            default: dec_kind = K_ILLEGAL;
        endcase
    end

    always_comb begin
        case (f3)
            3'd0:    take = alu_flags.eq;
            3'd1:    take = !alu_flags.eq;
            3'd4:    take = alu_flags.lt_s;
            3'd5:    take = !alu_flags.lt_s;
            3'd6:    take = alu_flags.lt_u;
            default: take = !alu_flags.lt_u;
        endcase
    end

    always_comb begin
        case (ld_kind_reg)
            LD_B:    ld_ext = {{24{lval_reg[7]}}, lval_reg[7:0]};
            LD_H:    ld_ext = {{16{lval_reg[15]}}, lval_reg[15:0]};
            LD_BU:   ld_ext = {24'b0, lval_reg[7:0]};
            LD_HU:   ld_ext = {16'b0, lval_reg[15:0]};
            default: ld_ext = lval_reg;
        endcase
    end

    always_comb begin
        case (f3)
            3'd0:    store_masked = {24'b0, rf_b[7:0]};
            3'd1:    store_masked = {16'b0, rf_b[15:0]};
            default: store_masked = rf_b;
        endcase
    end

    // Second pass of a taken branch adds the offset to the pc.
    assign alu_start = (state_reg == S_EXEC && !op_reg &&
                        (dec_kind == K_ALU || dec_kind == K_SLT || dec_kind == K_BRANCH ||
                         dec_kind == K_JAL || dec_kind == K_JALR || dec_kind == K_LOAD ||
                         dec_kind == K_STORE)) ||
                       (state_reg == S_ALU && alu_done && dec_kind == K_BRANCH &&
                        !pass2_reg && take);
    assign alu_x  = (state_reg == S_ALU) ? pc_reg : dec_x;
    assign alu_y  = (state_reg == S_ALU) ? imm_b : dec_y;
    assign alu_op = (state_reg == S_ALU) ? ALU_ADD : dec_op;

    assign md_start = (state_reg == S_EXEC) && !op_reg && (dec_kind == K_MD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pass2_reg     <= 1'b0;
            pc_reg        <= '0;
            retired_reg   <= '0;
            mask_reg      <= '0;
            trap_kind_reg <= TRAP_NONE;
            trap_loc_reg  <= '0;
            ld_pend_reg   <= 1'b0;
            ld_dest_reg   <= '0;
            ld_kind_reg   <= '0;
            sp_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Configuration: load pc or the stack pointer value.
            if (cfg_wr_en) begin
                if (cfg_index == CFG_START_ADDRESS) begin
                    pc_reg <= cfg_data;
                end else begin
                    sp_reg <= cfg_data;
                end
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg    <= s_operation;
                        insn_reg  <= s_instruction_word;
                        lval_reg  <= s_load_value;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    wb_en_reg      <= 1'b0;
                    wb_idx_reg     <= rd;
                    wb_val_reg     <= dec_val;
                    next_pc_reg    <= pc_plus4;
                    retire_reg     <= 1'b1;
                    trap_new_reg   <= TRAP_NONE;
                    req_reg        <= REQ_NONE;
                    size_reg       <= '0;
                    addr_reg       <= '0;
                    sdata_reg      <= '0;
                    mask_wr_reg    <= 1'b0;
                    load_issue_reg <= 1'b0;
                    load_clear_reg <= 1'b0;
                    pass2_reg      <= 1'b0;
                    if (op_reg) begin
                        // Load return: extend into the recorded destination.
                        next_pc_reg    <= pc_reg;
                        retire_reg     <= 1'b0;
                        wb_en_reg      <= ld_pend_reg;
                        wb_idx_reg     <= ld_dest_reg;
                        wb_val_reg     <= ld_ext;
                        load_clear_reg <= 1'b1;
                        state_reg      <= S_WB;
                    end else begin
                        case (dec_kind)
                            K_ILLEGAL, K_HALT: begin
                                next_pc_reg  <= pc_reg;
                                retire_reg   <= 1'b0;
                                trap_new_reg <= (dec_kind == K_HALT) ? TRAP_HALT : TRAP_ILLEGAL;
                                state_reg    <= S_WB;
                            end
                            K_DIRECT: begin
                                wb_en_reg <= 1'b1;
                                state_reg <= S_WB;
                            end
                            K_MASKIRQ: begin
                                wb_en_reg   <= 1'b1;
                                mask_wr_reg <= 1'b1;
                                state_reg   <= S_WB;
                            end
                            K_NONE: state_reg <= S_WB;
                            K_SHIFT: begin
                                sh_data_reg  <= rf_a;
                                sh_cnt_reg   <= dec_shamt;
                                sh_left_reg  <= dec_shift_left;
                                sh_arith_reg <= dec_shift_arith;
                                state_reg    <= S_SHIFT;
                            end
                            K_MD: state_reg <= S_MD;
                            default: state_reg <= S_ALU;
                        endcase
                    end
                end
                S_ALU: begin
                    if (alu_done) begin
                        state_reg <= S_WB;
                        case (dec_kind)
                            K_SLT: begin
                                wb_en_reg  <= 1'b1;
                                wb_val_reg <= {{(XLEN-1){1'b0}},
                                               dec_slt_signed ? alu_flags.lt_s : alu_flags.lt_u};
                            end
                            K_JAL: begin
                                wb_en_reg   <= 1'b1;
                                wb_val_reg  <= pc_plus4;
                                next_pc_reg <= alu_result;
                            end
                            K_JALR: begin
                                wb_en_reg   <= 1'b1;
                                wb_val_reg  <= pc_plus4;
                                next_pc_reg <= {alu_result[XLEN-1:1], 1'b0};
                            end
                            K_LOAD: begin
                                req_reg        <= REQ_LOAD;
                                size_reg       <= f3[1:0];
                                addr_reg       <= alu_result;
                                load_issue_reg <= 1'b1;
                            end
                            K_STORE: begin
                                req_reg   <= REQ_STORE;
                                size_reg  <= f3[1:0];
                                addr_reg  <= alu_result;
                                sdata_reg <= store_masked;
                            end
                            K_BRANCH: begin
                                if (pass2_reg) begin
                                    next_pc_reg <= alu_result;
                                end else if (take) begin
                                    pass2_reg <= 1'b1;
                                    state_reg <= S_ALU;
                                end
                            end
                            default: begin
                                wb_en_reg  <= 1'b1;
                                wb_val_reg <= alu_result;
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    // Advance one bit position per cycle.
                    if (sh_cnt_reg == '0) begin
                        wb_en_reg  <= 1'b1;
                        wb_val_reg <= sh_data_reg;
                        state_reg  <= S_WB;
                    end else begin
                        sh_cnt_reg <= sh_cnt_reg - 1'b1;
                        if (sh_left_reg) begin
                            sh_data_reg <= {sh_data_reg[XLEN-2:0], 1'b0};
                        end else begin
                            sh_data_reg <= {sh_arith_reg & sh_data_reg[XLEN-1],
                                            sh_data_reg[XLEN-1:1]};
                        end
                    end
                end
                S_MD: begin
                    if (md_done) begin
                        wb_en_reg  <= 1'b1;
                        wb_val_reg <= md_result;
                        state_reg  <= S_WB;
                    end
                end
                S_WB: begin
                    // Commit once the output register is free.
                    if (slot_free) begin
                        pc_reg <= next_pc_reg;
                        if (retire_reg) begin
                            retired_reg <= retired_reg + 1'b1;
                        end
                        if (trap_new_reg != TRAP_NONE) begin
                            trap_kind_reg <= trap_new_reg;
                            trap_loc_reg  <= pc_reg;
                        end
                        if (mask_wr_reg) begin
                            mask_reg <= rf_a;
                        end
                        if (load_issue_reg) begin
                            ld_pend_reg <= 1'b1;
                            ld_dest_reg <= rd;
                            ld_kind_reg <= f3;
                        end
                        if (load_clear_reg) begin
                            ld_pend_reg <= 1'b0;
                        end
                        m_valid_reg     <= 1'b1;
                        m_fetch_reg     <= next_pc_reg;
                        m_req_reg       <= req_reg;
                        m_size_reg      <= size_reg;
                        m_addr_reg      <= addr_reg;
                        m_sdata_reg     <= sdata_reg;
                        m_trap_reg      <= (trap_new_reg != TRAP_NONE) ? trap_new_reg
                                                                       : trap_kind_reg;
                        m_trap_addr_reg <= (trap_new_reg != TRAP_NONE) ? pc_reg
                                                                       : trap_loc_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    rvx_regs #(
        .REGISTER_COUNT(REGISTER_COUNT)
    ) u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr_a(s_instruction_word[19:15]),
        .rd_addr_b(s_instruction_word[24:20]),
        .rd_data_a(rf_a),
        .rd_data_b(rf_b),
        .wr_en    (rf_wr_en),
        .wr_addr  (wb_idx_reg),
        .wr_data  (wb_val_reg),
        .sp_value (sp_reg),
        .sp_load  (cfg_wr_en && cfg_index == CFG_START_SP)
    );

    rvx_alu u_alu (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (alu_start),
        .op     (alu_op),
        .x      (alu_x),
        .y      (alu_y),
        .done   (alu_done),
        .result (alu_result),
        .flags  (alu_flags)
    );

    rvx_muldiv u_muldiv (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (md_start),
        .func   (f3),
        .a      (rf_a),
        .b      (rf_b),
        .done   (md_done),
        .result (md_result)
    );

    assign m_valid          = m_valid_reg;
    assign m_fetch_address  = m_fetch_reg;
    assign m_memory_request = m_req_reg;
    assign m_access_size    = m_size_reg;
    assign m_access_address = m_addr_reg;
    assign m_store_value    = m_sdata_reg;
    assign m_trap_status    = m_trap_reg;
    assign m_trap_address   = m_trap_addr_reg;

`ifndef ASSERT_OFF
    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_WB))
        else $error("result appeared without a commit");
    a_alu_done_in_alu: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> state_reg == S_ALU)
        else $error("ALU finished outside its wait state");
    a_md_done_in_md: assert property (@(posedge aclk) disable iff (!aresetn)
        md_done |-> state_reg == S_MD)
        else $error("multiply/divide finished outside its wait state");
    a_retire_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && retire_reg) |=> retired_reg == $past(retired_reg) + 1'b1)
        else $error("retired count did not advance");
`endif

endmodule

@@ dv/rv32im_execute_step_top_tb.sv @@
// Self-checking testbench for the RV32IM execute step: directed and random programs.
`timescale 1ns / 100ps

module rv32im_execute_step_top_tb;
    import rvx_pkg::*;

    localparam int REG_COUNT = REGISTER_COUNT_DEFAULT;
    localparam int PHASES    = 5;
    localparam int RAND_PER_PHASE = 327;
    localparam int STALL_LIMIT = 6000;   // cycles without any handshake
    localparam int DRAIN_CYCLES = 45;    // longer than the slowest item

    // Item kinds on the input channel.
    localparam logic ITEM_EXEC   = 1'b0;
    localparam logic ITEM_RETURN = 1'b1;

    // funct3 codes used by the predictor and the program generator.
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4,
                           F3_BGE = 3'd5, F3_BLTU = 3'd6, F3_BGEU = 3'd7;
    localparam logic [2:0] F3_B = 3'd0, F3_H = 3'd1, F3_W = 3'd2,
                           F3_BU = 3'd4, F3_HU = 3'd5;
    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3,
                           F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
    localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_MULHSU = 3'd2,
                           F3_MULHU = 3'd3, F3_DIV = 3'd4, F3_DIVU = 3'd5,
                           F3_REM = 3'd6, F3_REMU = 3'd7;

    typedef struct packed {
        logic        op;
        logic [31:0] insn;
        logic [31:0] lval;
    } cpu_item_t;

    typedef struct packed {
        logic [31:0] fetch;
        logic [1:0]  req;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] sdata;
        logic [1:0]  trap;
        logic [31:0] trap_pc;
    } step_result_t;

    logic            aclk;
    logic            aresetn;
    logic            cfg_wr_en;
    logic            cfg_index;
    logic [XLEN-1:0] cfg_data;
    logic            s_valid;
    logic            s_ready;
    logic            s_operation;
    logic [XLEN-1:0] s_instruction_word;
    logic [XLEN-1:0] s_load_value;
    logic            m_valid;
    logic            m_ready;
    logic [XLEN-1:0] m_fetch_address;
    logic [1:0]      m_memory_request;
    logic [1:0]      m_access_size;
    logic [XLEN-1:0] m_access_address;
    logic [XLEN-1:0] m_store_value;
    logic [1:0]      m_trap_status;
    logic [XLEN-1:0] m_trap_address;

    rv32im_execute_step_top dut (.*);

    // Architectural state as the testbench sees it.
    logic [31:0] gpr [REG_COUNT];
    logic [31:0] pc_q;
    logic [63:0] retired;
    logic [31:0] int_mask;
    logic [1:0]  trap_kind;
    logic [31:0] trap_loc;
    logic        ld_pending;
    logic [4:0]  ld_dest;
    logic [2:0]  ld_kind;

    cpu_item_t    feed_q[$];     // items waiting to be driven
    step_result_t expect_q[$];   // predicted results, oldest first
    cpu_item_t    cur_item;
    int send_idle_pct, recv_stall_pct;
    int errors, items_done, results_seen, loads_seen, traps_seen, stores_seen;
    int quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [31:0] rd_reg(logic [4:0] idx);
        if (idx == 0 || idx >= REG_COUNT) return 32'd0;
        return gpr[idx];
    endfunction

    function automatic void wr_reg(logic [4:0] idx, logic [31:0] val);
        if (idx != 0 && idx < REG_COUNT) gpr[idx] = val;
    endfunction

    function automatic logic [31:0] muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        case (f3)
            F3_MUL: return a * b;
            F3_MULH: begin
                p = longint'($signed(a)) * longint'($signed(b));
                return p[63:32];
            end
            F3_MULHSU: begin
                p = longint'($signed(a)) * longint'({32'd0, b});
                return p[63:32];
            end
            F3_MULHU: begin
                p = {32'd0, a} * {32'd0, b};
                return p[63:32];
            end
            F3_DIV: begin
                if (b == 0) return 32'hffffffff;
                if (a == 32'h80000000 && b == 32'hffffffff) return a;
                return int'(a) / int'(b);
            end
            F3_DIVU: return (b == 0) ? 32'hffffffff : a / b;
            F3_REM: begin
                if (b == 0) return a;
                if (a == 32'h80000000 && b == 32'hffffffff) return 32'd0;
                return int'(a) % int'(b);
            end
            default: return (b == 0) ? a : a % b;
        endcase
    endfunction

    // Advance the architectural state by one item and return its result.
    function automatic step_result_t execute_item(cpu_item_t it);
        step_result_t r;
        logic [31:0] w, pc, nxt, a, b, v, imm_i, imm_s, imm_b, imm_j, imm_u;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [4:0]  rd, rs1, rs2;
        logic        ill, halt, take;
        r = '0;
        if (it.op == ITEM_RETURN) begin
            if (ld_pending) begin
                case (ld_kind)
                    F3_B:    v = {{24{it.lval[7]}}, it.lval[7:0]};
                    F3_H:    v = {{16{it.lval[15]}}, it.lval[15:0]};
                    F3_BU:   v = {24'd0, it.lval[7:0]};
                    F3_HU:   v = {16'd0, it.lval[15:0]};
                    default: v = it.lval;
                endcase
                wr_reg(ld_dest, v);
                ld_pending = 1'b0;
            end
        end else begin
            w = it.insn;
            pc = pc_q;
            rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; rs2 = w[24:20]; f7 = w[31:25];
            a = rd_reg(rs1);
            b = rd_reg(rs2);
            nxt = pc + 4;
            imm_i = {{20{w[31]}}, w[31:20]};
            imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
            imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            imm_u = {w[31:12], 12'd0};
            ill = 1'b0; halt = 1'b0; take = 1'b0;
            case (w[6:0])
                OP_LUI:   wr_reg(rd, imm_u);
                OP_AUIPC: wr_reg(rd, pc + imm_u);
                OP_JAL: begin
                    wr_reg(rd, pc + 4);
                    nxt = pc + imm_j;
                end
                OP_JALR: begin
                    if (f3 != 0) ill = 1'b1;
                    else begin
                        nxt = (a + imm_i) & ~32'd1;
                        wr_reg(rd, pc + 4);
                    end
                end
                OP_BRANCH: begin
                    case (f3)
                        F3_BEQ:  take = (a == b);
                        F3_BNE:  take = (a != b);
                        F3_BLT:  take = ($signed(a) < $signed(b));
                        F3_BGE:  take = !($signed(a) < $signed(b));
                        F3_BLTU: take = (a < b);
                        F3_BGEU: take = (a >= b);
                        default: ill = 1'b1;
                    endcase
                    if (take) nxt = pc + imm_b;
                end
                OP_LOAD: begin
                    if (f3 == 3'd3 || f3 > F3_HU) ill = 1'b1;
                    else begin
                        r.req = REQ_LOAD;
                        r.size = f3[1:0];
                        r.addr = a + imm_i;
                        ld_pending = 1'b1;
                        ld_dest = rd;
                        ld_kind = f3;
                    end
                end
                OP_STORE: begin
                    if (f3 > F3_W) ill = 1'b1;
                    else begin
                        r.req = REQ_STORE;
                        r.size = f3[1:0];
                        r.addr = a + imm_s;
                        r.sdata = (f3 == F3_B) ? (b & 32'hff) :
                                  (f3 == F3_H) ? (b & 32'hffff) : b;
                    end
                end
                OP_IMM: begin
                    case (f3)
                        F3_ADD:  wr_reg(rd, a + imm_i);
                        F3_SLT:  wr_reg(rd, {31'd0, $signed(a) < $signed(imm_i)});
                        F3_SLTU: wr_reg(rd, {31'd0, a < imm_i});
                        F3_XOR:  wr_reg(rd, a ^ imm_i);
                        F3_OR:   wr_reg(rd, a | imm_i);
                        F3_AND:  wr_reg(rd, a & imm_i);
                        F3_SLL: begin
                            if (f7 != F7_BASE) ill = 1'b1;
                            else wr_reg(rd, a << rs2);
                        end
                        default: begin
                            if (f7 == F7_ALT) wr_reg(rd, $signed(a) >>> rs2);
                            else if (f7 == F7_BASE) wr_reg(rd, a >> rs2);
                            else ill = 1'b1;
                        end
                    endcase
                end
                OP_REG: begin
                    if (f7 == F7_MULDIV) wr_reg(rd, muldiv(f3, a, b));
                    else if (f7 == F7_ALT) begin
                        if (f3 == F3_ADD) wr_reg(rd, a - b);
                        else if (f3 == F3_SR) wr_reg(rd, $signed(a) >>> b[4:0]);
                        else ill = 1'b1;
                    end else if (f7 != F7_BASE) ill = 1'b1;
                    else begin
                        case (f3)
                            F3_ADD:  wr_reg(rd, a + b);
                            F3_SLL:  wr_reg(rd, a << b[4:0]);
                            F3_SLT:  wr_reg(rd, {31'd0, $signed(a) < $signed(b)});
                            F3_SLTU: wr_reg(rd, {31'd0, a < b});
                            F3_XOR:  wr_reg(rd, a ^ b);
                            F3_SR:   wr_reg(rd, a >> b[4:0]);
                            F3_OR:   wr_reg(rd, a | b);
                            default: wr_reg(rd, a & b);
                        endcase
                    end
                end
                OP_FENCE: ;
                OP_CUSTOM0: begin
                    if (f3 == F3_MASKIRQ && f7 == F7_MASKIRQ) begin
                        v = int_mask;
                        int_mask = a;
                        wr_reg(rd, v);
                    end else ill = 1'b1;
                end
                OP_SYSTEM: begin
                    if (w == INSN_ECALL || w == INSN_EBREAK) halt = 1'b1;
                    else if (w[31:20] == CSR_CYCLE || w[31:20] == CSR_INSTRET)
                        wr_reg(rd, retired[31:0]);
                    else if (w[31:20] == CSR_CYCLEH || w[31:20] == CSR_INSTRETH)
                        wr_reg(rd, retired[63:32]);
                    else wr_reg(rd, 32'd0);
                end
                default: ill = 1'b1;
            endcase
            if (ill || halt) begin
                trap_kind = ill ? TRAP_ILLEGAL : TRAP_HALT;
                trap_loc = pc;
                r.req = REQ_NONE; r.size = '0; r.addr = '0; r.sdata = '0;
            end else begin
                pc_q = nxt;
                retired = retired + 1;
            end
        end
        r.fetch = pc_q;
        r.trap = trap_kind;
        r.trap_pc = trap_loc;
        return r;
    endfunction

    // Encoders for building programs.
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic void push_exec(logic [31:0] w);
        feed_q.push_back('{ITEM_EXEC, w, $urandom});
    endfunction

    function automatic void push_return(logic [31:0] lv);
        feed_q.push_back('{ITEM_RETURN, $urandom, lv});
    endfunction

    function automatic void build_directed();
        push_exec({20'h80000, 5'd1, OP_LUI});                       // x1 = min int
        push_exec(enc_i(12'hfff, 5'd0, F3_ADD, 5'd3, OP_IMM));       // x3 = -1
        push_exec(enc_r(F7_MULDIV, 5'd3, 5'd1, F3_DIV, 5'd4, OP_REG));  // overflow
        push_exec(enc_r(F7_MULDIV, 5'd0, 5'd1, F3_DIVU, 5'd5, OP_REG)); // divide by zero
        push_exec(enc_r(F7_MULDIV, 5'd3, 5'd1, F3_REM, 5'd6, OP_REG));
        push_exec(enc_r(F7_MULDIV, 5'd0, 5'd3, F3_REMU, 5'd7, OP_REG));
        push_exec(enc_r(F7_MULDIV, 5'd3, 5'd1, F3_MULH, 5'd8, OP_REG));
        push_exec(enc_r(F7_MULDIV, 5'd3, 5'd1, F3_MULHSU, 5'd8, OP_REG));
        push_exec(enc_r(F7_MULDIV, 5'd3, 5'd3, F3_MULHU, 5'd8, OP_REG));
        push_exec(enc_r(F7_ALT, 5'd31, 5'd1, F3_SR, 5'd9, OP_IMM));      // srai 31
        push_exec(enc_r(F7_BASE, 5'd3, 5'd3, F3_SLL, 5'd10, OP_REG));
        push_exec(enc_i(12'h800, 5'd3, F3_SLTU, 5'd12, OP_IMM));
        push_exec(enc_i(12'h000, 5'd2, F3_B, 5'd11, OP_LOAD));           // lb
        push_return(32'hffffff80);
        push_return(32'h12345678);                                       // nothing pending
        push_exec(enc_i(12'h7ff, 5'd1, F3_HU, 5'd13, OP_LOAD));          // lhu
        push_exec(enc_r(F7_BASE, 5'd13, 5'd13, F3_ADD, 5'd14, OP_REG));  // runs while pending
        push_return(32'hffff8001);
        push_exec({7'h7f, 5'd3, 5'd1, F3_B, 5'h1f, OP_STORE});           // sb, negative offset
        push_exec(enc_i(CSR_INSTRET, 5'd0, 3'd2, 5'd15, OP_SYSTEM));
        push_exec(enc_i(CSR_CYCLEH, 5'd0, 3'd2, 5'd16, OP_SYSTEM));
        push_exec(enc_i(12'h123, 5'd0, 3'd2, 5'd17, OP_SYSTEM));
        push_exec(enc_r(F7_MASKIRQ, 5'd0, 5'd3, F3_MASKIRQ, 5'd18, OP_CUSTOM0));
        push_exec(enc_r(F7_MASKIRQ, 5'd0, 5'd0, F3_MASKIRQ, 5'd18, OP_CUSTOM0));
        push_exec({25'd0, OP_FENCE});
        push_exec(INSN_ECALL);
        push_exec(32'd0);                                                // illegal
        push_exec(INSN_EBREAK);
        push_exec({1'b1, 10'h3fe, 1'b1, 8'hff, 5'd1, OP_JAL});           // jal backward
        push_exec({7'd0, 5'd0, 5'd0, F3_BEQ, 5'd8, OP_BRANCH});          // taken branch
    endfunction

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    endfunction

    // Mostly well-formed instructions with random operands, plus noise.
    function automatic void build_random(int count);
        logic [2:0] f3;
        logic [6:0] f7;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 15);
            f3 = 3'($urandom);
            case (kind)
                0: push_exec({20'($urandom), pick_reg(),
                              ($urandom_range(1) ? OP_LUI : OP_AUIPC)});
                1: push_exec({20'($urandom), pick_reg(), OP_JAL});
                2: push_exec(enc_i(12'($urandom), pick_reg(), 3'd0, pick_reg(), OP_JALR));
                3: begin
                    if (f3 == 3'd2 || f3 == 3'd3) f3 = F3_BEQ;
                    push_exec({7'($urandom), pick_reg(), pick_reg(), f3, 5'($urandom),
                               OP_BRANCH});
                end
                4, 5: begin
                    f3 = ($urandom_range(4) < 3) ? 3'($urandom_range(2)) : 3'($urandom_range(4, 5));
                    push_exec(enc_i(12'($urandom), pick_reg(), f3, pick_reg(), OP_LOAD));
                    if ($urandom_range(9) != 0) push_return($urandom);
                end
                6: push_exec({7'($urandom), pick_reg(), pick_reg(), 3'($urandom_range(2)),
                              5'($urandom), OP_STORE});
                7: begin
                    if (f3 == F3_SLL || f3 == F3_SR)
                        push_exec(enc_r((f3 == F3_SR && $urandom_range(1)) ? F7_ALT : F7_BASE,
                                        5'($urandom), pick_reg(), f3, pick_reg(), OP_IMM));
                    else
                        push_exec(enc_i(12'($urandom), pick_reg(), f3, pick_reg(), OP_IMM));
                end
                8: begin
                    f7 = F7_BASE;
                    if ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(1)) f7 = F7_ALT;
                    push_exec(enc_r(f7, pick_reg(), pick_reg(), f3, pick_reg(), OP_REG));
                end
                9, 10: push_exec(enc_r(F7_MULDIV, pick_reg(), pick_reg(), f3, pick_reg(), OP_REG));
                11: push_exec(($urandom_range(1) ? ($urandom & 32'hffffff80) : 32'd0) |
                              {25'd0, OP_FENCE});
                12: push_exec(enc_r(F7_MASKIRQ, 5'($urandom), pick_reg(), F3_MASKIRQ, pick_reg(),
                                    OP_CUSTOM0));
                13: begin
                    case ($urandom_range(4))
                        0: push_exec(enc_i(CSR_CYCLE, 5'($urandom), f3, pick_reg(), OP_SYSTEM));
                        1: push_exec(enc_i(CSR_INSTRET, 5'($urandom), f3, pick_reg(), OP_SYSTEM));
                        2: push_exec(enc_i(CSR_CYCLEH, 5'($urandom), f3, pick_reg(), OP_SYSTEM));
                        3: push_exec(enc_i(CSR_INSTRETH, 5'($urandom), f3, pick_reg(), OP_SYSTEM));
                        default: push_exec(($urandom & 32'hffffff80) | {25'd0, OP_SYSTEM});
                    endcase
                end
                14: begin
                    // noise: arbitrary words, stray returns, the odd halt
                    case ($urandom_range(5))
                        0: push_exec(INSN_ECALL);
                        1: push_exec(INSN_EBREAK);
                        2: push_return($urandom);
                        default: push_exec($urandom);
                    endcase
                end
                default: push_exec(enc_r(7'($urandom), pick_reg(), pick_reg(), f3, pick_reg(),
                                         ($urandom_range(1) ? OP_REG : OP_IMM)));
            endcase
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    // Driver: hold an item until taken, then fetch the next one or idle.
    always @(posedge aclk) begin
        logic nv;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nv = s_valid;
            if (s_valid && s_ready) begin
                expect_q.push_back(execute_item(cur_item));
                items_done++;
                nv = 1'b0;
            end
            if (!nv && feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_item = feed_q.pop_front();
                s_operation <= cur_item.op;
                s_instruction_word <= cur_item.insn;
                s_load_value <= cur_item.lval;
                nv = 1'b1;
            end
            s_valid <= nv;
        end
    end

    // Monitor: compare each result with the oldest prediction, stall at random.
    always @(posedge aclk) begin
        step_result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, fetch %h", $time,
                             m_fetch_address);
                end else begin
                    e = expect_q.pop_front();
                    check_field("fetch_address", e.fetch, m_fetch_address);
                    check_field("memory_request", e.req, m_memory_request);
                    check_field("access_size", e.size, m_access_size);
                    check_field("access_address", e.addr, m_access_address);
                    check_field("store_value", e.sdata, m_store_value);
                    check_field("trap_status", e.trap, m_trap_status);
                    check_field("trap_address", e.trap_pc, m_trap_address);
                    if (e.req == REQ_LOAD) loads_seen++;
                    if (e.req == REQ_STORE) stores_seen++;
                    if (e.trap != TRAP_NONE) traps_seen++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any handshake resets the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Write one register at a clock edge and mirror it in the predicted state.
    task automatic write_cfg(logic idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_START_ADDRESS) pc_q = val;
        else gpr[2] = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (feed_q.size() != 0 || s_valid || expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] start_pc [PHASES];
        logic [31:0] start_sp [PHASES];
        int idle_send [PHASES];
        int idle_recv [PHASES];
        start_pc = '{32'h0, 32'hffffffff, 32'h00001000, $urandom, 32'hfffffffc};
        start_sp = '{32'h0, 32'hffffffff, 32'h80000000, $urandom, 32'h7ffffff0};
        idle_send = '{0, 72, 0, 35, 0};
        idle_recv = '{0, 0, 72, 35, 0};

        aresetn = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = CFG_START_ADDRESS; cfg_data = '0;
        s_valid = 1'b0; s_operation = ITEM_EXEC; s_instruction_word = '0; s_load_value = '0;
        m_ready = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0;
        errors = 0; items_done = 0; results_seen = 0;
        loads_seen = 0; stores_seen = 0; traps_seen = 0;

        // Reset state of the architectural model.
        foreach (gpr[i]) gpr[i] = POISON_WORD;
        gpr[0] = '0; gpr[2] = '0;
        pc_q = '0; retired = '0; int_mask = '0;
        trap_kind = TRAP_NONE; trap_loc = '0;
        ld_pending = 1'b0; ld_dest = '0; ld_kind = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Start from reset values, then reprogram between phases.
        build_directed();
        wait_idle();
        for (int ph = 0; ph < PHASES; ph++) begin
            write_cfg(CFG_START_ADDRESS, start_pc[ph]);
            write_cfg(CFG_START_SP, start_sp[ph]);
            send_idle_pct = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            build_random(RAND_PER_PHASE);
            wait_idle();
        end

        $display("run: %0d items, %0d results, %0d loads, %0d stores, %0d trapping results",
                 items_done, results_seen, loads_seen, stores_seen, traps_seen);
        $display("run: %0d phases of start address and stack pointer, idle mixes included",
                 PHASES);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
